[sv/app_pkg.sv]
// Shared types, widths, codes and saturation helpers for the alignment position projector.
// Used by app_step and alignment_position_projector; app_ram is generic and does not use it.
package app_pkg;

    localparam int POS_W      = 31;
    localparam int END_W      = 32;
    localparam int GAP_W      = 22;
    localparam int LEN_W      = 20;
    localparam int DIST_W     = 21;
    localparam int MAX_BLOCKS = 256;
    localparam int IDX_W      = 8;
    localparam int CNT_W      = 9;
    localparam int WALK_W     = 33;
    localparam int ENTRY_W    = GAP_W + LEN_W;

    localparam logic [1:0] MODE_BEGIN      = 2'd0;
    localparam logic [1:0] MODE_APPEND     = 2'd1;
    localparam logic [1:0] MODE_QUERY_ONE  = 2'd2;
    localparam logic [1:0] MODE_QUERY_TWO  = 2'd3;

    localparam logic [1:0] STATUS_INSIDE = 2'd0;
    localparam logic [1:0] STATUS_BEFORE = 2'd1;
    localparam logic [1:0] STATUS_AFTER  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WALK,
        ST_FINISH,
        ST_DONE
    } t_state;

    // Result of one block step of the walk
    typedef struct packed {
        logic              gap_hit;
        logic              len_hit;
        logic [DIST_W-1:0] gap_dist;
        logic [WALK_W-1:0] rem_next;
        logic [WALK_W-1:0] oth_next;
    } t_step_res;

    function automatic logic [POS_W-1:0] sat_pos(input logic [WALK_W:0] v);
        logic [WALK_W:0] lim;
        lim = (WALK_W+1)'({POS_W{1'b1}});
        return (v > lim) ? {POS_W{1'b1}} : v[POS_W-1:0];
    endfunction

    function automatic logic [END_W-1:0] sat_end(input logic [END_W:0] v);
        return v[END_W] ? {END_W{1'b1}} : v[END_W-1:0];
    endfunction

endpackage

[sv/app_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module app_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/app_step.sv]
// Block step unit: examines one table block against the distance left to the query.
// Depends on app_pkg.
module app_step (
    input  logic signed [app_pkg::GAP_W-1:0]  i_gap,
    input  logic        [app_pkg::LEN_W-1:0]  i_len,
    input  logic                              i_side,
    input  logic        [app_pkg::WALK_W-1:0] i_rem,
    input  logic        [app_pkg::WALK_W-1:0] i_oth,
    output app_pkg::t_step_res                o_res
);

    logic [app_pkg::GAP_W-1:0]  mag;
    logic                       neg;
    logic                       pos;
    logic                       skip;
    logic [app_pkg::GAP_W:0]    sum_ml;
    logic [app_pkg::GAP_W:0]    own_adv;
    logic [app_pkg::GAP_W:0]    oth_adv;
    logic [app_pkg::GAP_W:0]    own_pre;
    logic [app_pkg::GAP_W:0]    oth_pre;
    logic [app_pkg::WALK_W-1:0] mag_w;
    logic [app_pkg::GAP_W:0]    dist_raw;
    logic                       gap_hit;
    logic                       len_hit;

    always_comb begin
        neg     = i_gap[app_pkg::GAP_W-1];
        pos     = !neg && (|i_gap);
        mag     = neg ? app_pkg::GAP_W'(-i_gap) : app_pkg::GAP_W'(i_gap);
        // A gap skips the queried sequence when its sign points at it
        skip    = i_side ? pos : neg;
        sum_ml  = (app_pkg::GAP_W+1)'(mag) + (app_pkg::GAP_W+1)'(i_len);
        own_adv = skip ? sum_ml : (app_pkg::GAP_W+1)'(i_len);
        oth_adv = skip ? (app_pkg::GAP_W+1)'(i_len) : sum_ml;
        own_pre = skip ? (app_pkg::GAP_W+1)'(mag) : '0;
        oth_pre = skip ? '0 : (app_pkg::GAP_W+1)'(mag);
        mag_w   = app_pkg::WALK_W'(mag);

        gap_hit = skip && (i_rem <= mag_w);
        len_hit = !gap_hit && (i_rem <= app_pkg::WALK_W'(own_adv));

        // Bases left in the gap: mag - (rem - 1)
        dist_raw = (app_pkg::GAP_W+1)'(mag) - (app_pkg::GAP_W+1)'(i_rem[app_pkg::GAP_W-1:0])
                 + (app_pkg::GAP_W+1)'(1);

        o_res.gap_hit  = gap_hit;
        o_res.len_hit  = len_hit;
        o_res.gap_dist = (dist_raw > (app_pkg::GAP_W+1)'({app_pkg::DIST_W{1'b1}}))
                       ? {app_pkg::DIST_W{1'b1}} : dist_raw[app_pkg::DIST_W-1:0];
        // On a run hit, step only past the gap so the finish adds the offset
        o_res.rem_next = i_rem - app_pkg::WALK_W'(len_hit ? own_pre : own_adv);
        o_res.oth_next = i_oth + app_pkg::WALK_W'(len_hit ? oth_pre : oth_adv);
    end

endmodule

[sv/alignment_position_projector.sv]
// Top level of the alignment position projector: sequencer, alignment registers,
// block table RAM and result register. Depends on app_pkg, app_ram and app_step.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one transaction per command: begin,
//   append or a query on sequence one or two. Output channel (o_valid / i_ready)
//   carries one result per query; begin and append give none.
//   Begin and append complete in the accepting cycle and leave o_ready high.
//   A query first passes the range check, then walks the block table one block
//   per cycle through the shared step unit. A query outside the alignment, at its
//   start or with an empty table goes from the check to the result; a hit inside
//   a gap, or a walk that runs off the table, ends the walk there; a hit inside
//   a block passes a finish state to form the mapped position. The table holds
//   up to 256 blocks. One transaction is in work at a time; o_ready is high only
//   while the sequencer is idle. The result register holds its transaction until
//   taken; a finished query waits in the sequencer, with o_ready low, while the
//   previous result is still stalled.
//   Reset clears the starts, ends, block count and overflow flag; the table
//   RAM is not cleared, since only entries written since the last begin are read.
module alignment_position_projector (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic        [1:0]                   i_mode,
    input  logic        [app_pkg::POS_W-1:0]    i_start_first,
    input  logic        [app_pkg::POS_W-1:0]    i_start_second,
    input  logic signed [app_pkg::GAP_W-1:0]    i_block_gap,
    input  logic        [app_pkg::LEN_W-1:0]    i_block_length,
    input  logic        [app_pkg::POS_W-1:0]    i_query_position,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic        [app_pkg::POS_W-1:0]    o_mapped_position,
    output logic        [app_pkg::DIST_W-1:0]   o_gap_distance,
    output logic        [1:0]                   o_range_status,
    output logic                                o_overflowed
);

    app_pkg::t_state r_state;
    app_pkg::t_state n_state;

    logic [app_pkg::POS_W-1:0]  r_first_start;
    logic [app_pkg::POS_W-1:0]  r_second_start;
    logic [app_pkg::END_W-1:0]  r_first_end;
    logic [app_pkg::END_W-1:0]  r_second_end;
    logic [app_pkg::CNT_W-1:0]  r_count;
    logic                       r_overflow;
    logic [app_pkg::POS_W-1:0]  r_q;
    logic                       r_side;
    logic [app_pkg::IDX_W-1:0]  r_idx;
    logic [app_pkg::WALK_W-1:0] r_rem;
    logic [app_pkg::WALK_W-1:0] r_oth;
    logic [app_pkg::POS_W-1:0]  r_res_mapped;
    logic [app_pkg::DIST_W-1:0] r_res_dist;
    logic [1:0]                 r_res_status;
    logic                       r_out_valid;
    logic [app_pkg::POS_W-1:0]  r_out_mapped;
    logic [app_pkg::DIST_W-1:0] r_out_dist;
    logic [1:0]                 r_out_status;
    logic                       r_out_ovf;

    // Sequencer outputs
    logic                       in_ready;
    logic                       ram_we;
    logic [app_pkg::IDX_W-1:0]  ram_raddr;
    logic                       out_load;

    logic                       in_acc;
    logic                       table_full;
    logic [app_pkg::ENTRY_W-1:0] ram_rdata;
    logic signed [app_pkg::GAP_W-1:0] rd_gap;
    logic [app_pkg::LEN_W-1:0]  rd_len;
    app_pkg::t_step_res         step;

    // Range check signals
    logic [app_pkg::POS_W-1:0]  own_start;
    logic [app_pkg::POS_W-1:0]  oth_start;
    logic [app_pkg::END_W-1:0]  own_end;
    logic                       q_before;
    logic                       q_after;
    logic                       q_at;
    logic                       walk_last;

    // Append arithmetic
    logic                       app_neg;
    logic                       app_pos;
    logic [app_pkg::GAP_W-1:0]  app_mag;
    logic [app_pkg::GAP_W:0]    inc_first;
    logic [app_pkg::GAP_W:0]    inc_second;
    logic [app_pkg::END_W:0]    sum_first;
    logic [app_pkg::END_W:0]    sum_second;

    assign in_acc     = i_valid && in_ready;
    assign table_full = r_count[app_pkg::IDX_W];

    always_comb begin
        app_neg    = i_block_gap[app_pkg::GAP_W-1];
        app_pos    = !app_neg && (|i_block_gap);
        app_mag    = app_neg ? app_pkg::GAP_W'(-i_block_gap) : app_pkg::GAP_W'(i_block_gap);
        inc_first  = (app_neg ? (app_pkg::GAP_W+1)'(app_mag) : '0)
                   + (app_pkg::GAP_W+1)'(i_block_length);
        inc_second = (app_pos ? (app_pkg::GAP_W+1)'(app_mag) : '0)
                   + (app_pkg::GAP_W+1)'(i_block_length);
        sum_first  = (app_pkg::END_W+1)'(r_first_end) + (app_pkg::END_W+1)'(inc_first);
        sum_second = (app_pkg::END_W+1)'(r_second_end) + (app_pkg::END_W+1)'(inc_second);
    end

    always_comb begin
        own_start = r_side ? r_second_start : r_first_start;
        oth_start = r_side ? r_first_start : r_second_start;
        own_end   = r_side ? r_second_end : r_first_end;
        q_before  = r_q < own_start;
        q_after   = app_pkg::END_W'(r_q) > own_end;
        q_at      = r_q == own_start;
        walk_last = (app_pkg::CNT_W'(r_idx) + app_pkg::CNT_W'(1)) == r_count;
    end

    app_ram #(
        .WIDTH (app_pkg::ENTRY_W),
        .DEPTH (app_pkg::MAX_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[app_pkg::IDX_W-1:0]),
        .i_wdata ({i_block_gap, i_block_length}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_gap = ram_rdata[app_pkg::ENTRY_W-1 -: app_pkg::GAP_W];
    assign rd_len = ram_rdata[app_pkg::LEN_W-1:0];

    app_step u_step (
        .i_gap  (rd_gap),
        .i_len  (rd_len),
        .i_side (r_side),
        .i_rem  (r_rem),
        .i_oth  (r_oth),
        .o_res  (step)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            app_pkg::ST_IDLE: begin
                if (in_acc && (i_mode == app_pkg::MODE_QUERY_ONE
                               || i_mode == app_pkg::MODE_QUERY_TWO)) begin
                    n_state = app_pkg::ST_CHECK;
                end
            end
            app_pkg::ST_CHECK: begin
                if (q_before || q_after || q_at || r_count == '0) begin
                    n_state = app_pkg::ST_DONE;
                end else begin
                    n_state = app_pkg::ST_WALK;
                end
            end
            app_pkg::ST_WALK: begin
                if (step.gap_hit) begin
                    n_state = app_pkg::ST_DONE;
                end else if (step.len_hit) begin
                    n_state = app_pkg::ST_FINISH;
                end else if (walk_last) begin
                    n_state = app_pkg::ST_DONE;
                end
            end
            app_pkg::ST_FINISH: n_state = app_pkg::ST_DONE;
            app_pkg::ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_state = app_pkg::ST_IDLE;
                end
            end
            default: n_state = app_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        in_ready  = 1'b0;
        ram_we    = 1'b0;
        ram_raddr = '0;
        out_load  = 1'b0;
        unique case (r_state)
            app_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                ram_we   = i_valid && (i_mode == app_pkg::MODE_APPEND) && !table_full;
            end
            app_pkg::ST_CHECK: ram_raddr = '0;
            app_pkg::ST_WALK: ram_raddr = r_idx + app_pkg::IDX_W'(1);
            app_pkg::ST_FINISH: ram_raddr = '0;
            app_pkg::ST_DONE: out_load = !r_out_valid || i_ready;
            default: ram_raddr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= app_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Alignment registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_start  <= '0;
            r_second_start <= '0;
            r_first_end    <= '0;
            r_second_end   <= '0;
            r_count        <= '0;
            r_overflow     <= 1'b0;
        end else if (in_acc) begin
            unique case (i_mode)
                app_pkg::MODE_BEGIN: begin
                    r_first_start  <= i_start_first;
                    r_second_start <= i_start_second;
                    r_first_end    <= app_pkg::END_W'(i_start_first);
                    r_second_end   <= app_pkg::END_W'(i_start_second);
                    r_count        <= '0;
                end
                app_pkg::MODE_APPEND: begin
                    if (table_full) begin
                        r_overflow <= 1'b1;
                    end else begin
                        r_count      <= r_count + app_pkg::CNT_W'(1);
                        r_first_end  <= app_pkg::sat_end(sum_first);
                        r_second_end <= app_pkg::sat_end(sum_second);
                    end
                end
                default: begin
                    r_overflow <= r_overflow;
                end
            endcase
        end
    end

    // Walk and result datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            app_pkg::ST_IDLE: begin
                r_q    <= i_query_position;
                r_side <= (i_mode == app_pkg::MODE_QUERY_TWO);
            end
            app_pkg::ST_CHECK: begin
                r_idx        <= '0;
                r_rem        <= app_pkg::WALK_W'(r_q - own_start);
                r_oth        <= app_pkg::WALK_W'(oth_start);
                r_res_dist   <= '0;
                r_res_mapped <= '0;
                if (q_before) begin
                    r_res_status <= app_pkg::STATUS_BEFORE;
                end else if (q_after || (!q_at && r_count == '0)) begin
                    r_res_status <= app_pkg::STATUS_AFTER;
                end else begin
                    r_res_status <= app_pkg::STATUS_INSIDE;
                    r_res_mapped <= oth_start;
                end
            end
            app_pkg::ST_WALK: begin
                if (step.gap_hit) begin
                    r_res_mapped <= app_pkg::sat_pos({1'b0, r_oth});
                    r_res_dist   <= step.gap_dist;
                    r_res_status <= app_pkg::STATUS_INSIDE;
                end else begin
                    r_rem <= step.rem_next;
                    r_oth <= step.oth_next;
                    r_idx <= r_idx + app_pkg::IDX_W'(1);
                    // Walk ran off the table: report after end
                    if (!step.len_hit && walk_last) begin
                        r_res_mapped <= '0;
                        r_res_dist   <= '0;
                        r_res_status <= app_pkg::STATUS_AFTER;
                    end
                end
            end
            app_pkg::ST_FINISH: begin
                r_res_mapped <= app_pkg::sat_pos((app_pkg::WALK_W+1)'(r_oth)
                                               + (app_pkg::WALK_W+1)'(r_rem));
                r_res_dist   <= '0;
                r_res_status <= app_pkg::STATUS_INSIDE;
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_mapped <= r_res_mapped;
            r_out_dist   <= r_res_dist;
            r_out_status <= r_res_status;
            r_out_ovf    <= r_overflow;
        end
    end

    assign o_ready           = in_ready;
    assign o_valid           = r_out_valid;
    assign o_mapped_position = r_out_mapped;
    assign o_gap_distance    = r_out_dist;
    assign o_range_status    = r_out_status;
    assign o_overflowed      = r_out_ovf;

endmodule
